@@ rtl/core/egcd_pkg.sv @@
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared widths for the extended gcd unit.
// ----------------------------------------------------------------------------
package egcd_pkg;

	// Operand port width.
	localparam int unsigned IN_W   = 31;
	// Reported gcd width.
	localparam int unsigned DIV_W  = 31;
	// Bezout coefficients are kept modulo 2^COEF_W.
	localparam int unsigned COEF_W = 32;

	typedef logic signed [COEF_W-1:0] coef_t;

endpackage

@@ rtl/core/extended_gcd_unit.sv @@
// ----------------------------------------------------------------------------
// extended_gcd_unit
// Extended Euclid: gcd plus Bezout coefficients of two unsigned operands.
// ----------------------------------------------------------------------------
// Usage:
//   Drive first_value/second_value and pulse start while busy is low; that
//   edge takes the beat. busy stays high until the result is out. The result
//   (divisor, coef_large, coef_small, swapped) is valid for exactly one cycle
//   with done high; the receiver cannot stall it, so it must take it then.
//   The larger operand comes first: divisor = coef_large*larger +
//   coef_small*smaller. A zero smaller operand skips the Euclid steps.
// Operation:
//   Each Euclid step runs on one shared compare/subtract unit: ST_ALIGN
//   shifts the divisor up to the remainder (its last pass sees no further
//   shift), ST_DIV does restoring division, one quotient bit per pass, with
//   the q*coef products built by shift-add in the same cycles, and ST_UPD
//   updates remainder and coefficients. One item is in flight at a time.
// Reset:
//   arst_n clears the sequencer and the done strobe; no item is kept.
// ----------------------------------------------------------------------------
module extended_gcd_unit #(
	parameter int unsigned WIDTH = 31
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [egcd_pkg::IN_W-1:0]         first_value,
	input  logic [egcd_pkg::IN_W-1:0]         second_value,
	output logic                              done,
	output logic [egcd_pkg::DIV_W-1:0]        divisor,
	output logic signed [egcd_pkg::COEF_W-1:0] coef_large,
	output logic signed [egcd_pkg::COEF_W-1:0] coef_small,
	output logic                              swapped
);

	// Operand bits above WIDTH (capped at the port width) never reach the datapath.
	localparam int unsigned OPW = (WIDTH < egcd_pkg::IN_W) ? WIDTH : egcd_pkg::IN_W;
	localparam int unsigned CW  = $clog2(OPW);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_DIV,
		ST_UPD
	} state_t;

	state_t            state_q;
	logic [OPW-1:0]    nr_q, rem_q, d_q;
	logic [CW-1:0]     cnt_q;
	egcd_pkg::coef_t   s_q, ns_q, t_q, nt_q, ps_q, pt_q;

	logic [OPW-1:0]    a_in, b_in;
	logic              swap_in;
	logic              qbit;
	logic [OPW-1:0]    rem_sub;
	logic              can_grow;

	assign a_in    = swap_in ? second_value[OPW-1:0] : first_value[OPW-1:0];
	assign b_in    = swap_in ? first_value[OPW-1:0]  : second_value[OPW-1:0];
	assign swap_in = first_value[OPW-1:0] < second_value[OPW-1:0];

	// shared compare/subtract unit
	assign qbit    = rem_q >= d_q;
	assign rem_sub = rem_q - d_q;
	assign can_grow = !d_q[OPW-1] && ({1'b0, d_q, 1'b0} <= {2'b00, rem_q});

	assign busy = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						nr_q    <= b_in;
						s_q     <= egcd_pkg::coef_t'(1);
						ns_q    <= '0;
						t_q     <= '0;
						nt_q    <= egcd_pkg::coef_t'(1);
						rem_q   <= a_in;
						d_q     <= b_in;
						cnt_q   <= '0;
						ps_q    <= '0;
						pt_q    <= '0;
						swapped <= swap_in;
						if (b_in == '0) begin
							done       <= 1'b1;
							divisor    <= egcd_pkg::DIV_W'(a_in);
							coef_large <= egcd_pkg::coef_t'(1);
							coef_small <= '0;
						end else begin
							state_q <= ST_ALIGN;
						end
					end
				end
				ST_ALIGN: begin
					if (can_grow) begin
						d_q   <= {d_q[OPW-2:0], 1'b0};
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// quotient MSB first; Horner form gives q*ns and q*nt
					if (qbit) begin
						rem_q <= rem_sub;
						ps_q  <= {ps_q[egcd_pkg::COEF_W-2:0], 1'b0} + ns_q;
						pt_q  <= {pt_q[egcd_pkg::COEF_W-2:0], 1'b0} + nt_q;
					end else begin
						ps_q  <= {ps_q[egcd_pkg::COEF_W-2:0], 1'b0};
						pt_q  <= {pt_q[egcd_pkg::COEF_W-2:0], 1'b0};
					end
					if (cnt_q == '0) begin
						state_q <= ST_UPD;
					end else begin
						d_q   <= d_q >> 1;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_UPD: begin
					nr_q <= rem_q;
					s_q  <= ns_q;
					ns_q <= s_q - ps_q;
					t_q  <= nt_q;
					nt_q <= t_q - pt_q;
					if (rem_q == '0) begin
						done       <= 1'b1;
						divisor    <= egcd_pkg::DIV_W'(nr_q);
						coef_large <= ns_q;
						coef_small <= nt_q;
						state_q    <= ST_IDLE;
					end else begin
						// next step divides old divisor by this remainder
						rem_q   <= nr_q;
						d_q     <= rem_q;
						cnt_q   <= '0;
						ps_q    <= '0;
						pt_q    <= '0;
						state_q <= ST_ALIGN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer still busy");

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted beat neither started nor finished");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALIGN || state_q == ST_DIV) |-> (d_q != '0))
		else $error("division by zero in Euclid step");

	a_qbit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> ({1'b0, rem_q} < {d_q, 1'b0}))
		else $error("partial remainder exceeds twice the shifted divisor");

	a_upd_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> (rem_q < nr_q))
		else $error("remainder not below divisor after division");
`endif

endmodule
